// ===== src/acmac_pkg.sv =====
// Package for the AES-128 CMAC signer: types, constants, S-box and round functions.
// No dependencies; used by acmac_ctrl, acmac_dp and aes_cmac_signer.
package acmac_pkg;

    localparam int AES_ROUNDS_DEF = 10;
    localparam int BLOCK_BYTES    = 16;
    localparam int KEY_W          = 64;
    localparam logic [7:0] CMAC_RB = 8'h87;

    typedef enum logic [1:0]
    {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_KEYGEN,
        ST_SUBKEY,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic key_start;   // load key into schedule register, rcon = 1
        logic l_start;     // load zero block xor key
        logic blk_start;   // load chain ^ block (^ K1) xor key
        logic round;       // run one round, advance key schedule
        logic final_rnd;   // this round is the last one, skip MixColumns
        logic save_k1;     // capture K1 from state
        logic save_chain;  // capture ciphertext into chain, or clear on last
        logic last;        // current word is a final block
    } cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic dummy;
    } status_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits at bits [127-8i -: 8]
    function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    // SubBytes, ShiftRows and (unless final) MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
        logic [7:0] t [16];
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
            t[i] = sbox(byte_of(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4)));
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            if (final_rnd)
            begin
                o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end
            else
            begin
                o[127 - 32 * c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

    // Next round key from the current one
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== src/acmac_ctrl.sv =====
// Controller for the CMAC signer: sequences subkey derivation and block rounds.
// Depends on acmac_pkg.
module acmac_ctrl #(
    parameter int AES_ROUNDS = acmac_pkg::AES_ROUNDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_block,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output acmac_pkg::cmd_t   cmd,
    input  acmac_pkg::status_t sts
);
    import acmac_pkg::*;

    localparam int RW = $clog2(AES_ROUNDS + 1);

    state_t        state_reg, state_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic          ready_reg, ready_next;
    logic          last_reg, last_next;
    logic          key_wr;

    assign key_wr = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

    // Hold state, round count, subkey flag and last-word flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            ready_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            ready_reg <= ready_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        ready_next = key_wr ? 1'b0 : ready_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.last   = last_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    last_next = last_block;
                    if (ready_reg)
                    begin
                        cmd.blk_start = 1'b1;
                        cmd.key_start = 1'b1;
                        cmd.last      = last_block;
                        rnd_next      = RW'(1);
                        state_next    = ST_ROUND;
                    end
                    else
                    begin
                        cmd.key_start = 1'b1;
                        cmd.l_start   = 1'b1;
                        rnd_next      = RW'(1);
                        state_next    = ST_SUBKEY;
                    end
                end
            end
            // Encrypt zero block to get L
            ST_SUBKEY:
            begin
                if (rnd_reg == RW'(AES_ROUNDS + 1))
                begin
                    cmd.save_k1 = 1'b1;
                    ready_next  = 1'b1;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    cmd.round     = 1'b1;
                    cmd.final_rnd = (rnd_reg == RW'(AES_ROUNDS));
                    rnd_next      = rnd_reg + RW'(1);
                end
            end
            ST_LOAD:
            begin
                cmd.blk_start = 1'b1;
                cmd.key_start = 1'b1;
                rnd_next      = RW'(1);
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == RW'(AES_ROUNDS + 1))
                begin
                    cmd.save_chain = 1'b1;
                    state_next     = last_reg ? ST_OUT : ST_IDLE;
                end
                else
                begin
                    cmd.round     = 1'b1;
                    cmd.final_rnd = (rnd_reg == RW'(AES_ROUNDS));
                    rnd_next      = rnd_reg + RW'(1);
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic unused_sts;
    assign unused_sts = sts.dummy;

endmodule

// ===== src/acmac_dp.sv =====
// Datapath for the CMAC signer: AES state, key schedule, chain, K1 and tag.
// Depends on acmac_pkg.
module acmac_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic                    in_take,
    input  logic [63:0]             block_high,
    input  logic [63:0]             block_low,
    input  acmac_pkg::cmd_t         cmd,
    output acmac_pkg::status_t      sts,
    output logic [63:0]             mac_high,
    output logic [63:0]             mac_low
);
    import acmac_pkg::*;

    logic [127:0] key_reg;
    logic [127:0] blk_reg, blk_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [127:0] chain_reg;
    logic [127:0] k1_reg;
    logic [127:0] mac_reg;
    logic [127:0] nk;
    logic [127:0] inblk;

    assign nk = next_key(rk_reg, rc_reg);
    assign inblk = chain_reg ^ blk_reg ^ (cmd.last ? k1_reg : '0);

    // Key registers and chain are control-visible, so reset them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            chain_reg <= '0;
            k1_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_KEY_HIGH)
                key_reg[127:64] <= cfg_data;
            if (cfg_we && cfg_index == CFG_KEY_LOW)
                key_reg[63:0] <= cfg_data;
            if (cmd.save_k1)
                k1_reg <= {st_reg[126:0], 1'b0} ^ {120'd0, st_reg[127] ? CMAC_RB : 8'h00};
            if (cmd.save_chain)
                chain_reg <= cmd.last ? '0 : st_reg;
        end
    end

    always_comb
    begin
        blk_next = in_take ? {block_high, block_low} : blk_reg;
        st_next  = st_reg;
        rk_next  = rk_reg;
        rc_next  = rc_reg;
        if (cmd.key_start)
        begin
            rk_next = key_reg;
            rc_next = 8'h01;
        end
        else if (cmd.round)
        begin
            rk_next = nk;
            rc_next = xtime(rc_reg);
        end
        if (cmd.l_start)
            st_next = key_reg;
        else if (cmd.blk_start)
            st_next = (in_take ? ({block_high, block_low} ^ chain_reg ^
                      (cmd.last ? k1_reg : '0)) : inblk) ^ key_reg;
        else if (cmd.round)
            st_next = aes_round(st_reg, cmd.final_rnd) ^ nk;
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        st_reg  <= st_next;
        rk_reg  <= rk_next;
        rc_reg  <= rc_next;
        if (cmd.save_chain && cmd.last)
            mac_reg <= st_reg;
    end

    assign mac_high  = mac_reg[127:64];
    assign mac_low   = mac_reg[63:0];
    assign sts.dummy = 1'b0;

endmodule

// ===== src/aes_cmac_signer.sv =====
// Top level of the AES-128 CMAC signer.
// Depends on acmac_pkg, acmac_ctrl, acmac_dp.
//
//  channel | signals                                     | direction
//  in      | in_valid, in_stall, block_high/low, last_block | word in
//  out     | out_valid, out_stall, mac_high/low            | word out
//  cfg     | cfg_we, cfg_index, cfg_data                   | key write
//
// A word is a load, ten rounds and a chain update on the single round unit, and
// in_stall holds high; the first word after reset or a key write derives K1 too.
// A final word then shows its tag until out_stall is low.
// Reset clears key, chain, K1 and the subkey flag; no sweep is needed.
module aes_cmac_signer #(
    parameter int AES_ROUNDS = acmac_pkg::AES_ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] mac_high,
    output logic [63:0] mac_low
);
    import acmac_pkg::*;

    cmd_t    cmd;
    status_t sts;

    acmac_ctrl #(.AES_ROUNDS(AES_ROUNDS)) u_ctrl (
        .clk, .rst_n, .in_valid, .last_block, .cfg_we, .cfg_index, .out_stall,
        .in_stall, .out_valid, .cmd, .sts
    );

    acmac_dp u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_take(in_valid && !in_stall), .block_high, .block_low,
        .cmd, .sts, .mac_high, .mac_low
    );

endmodule

// ===== src/acmac_checker.sv =====
// Port-level checks for the CMAC signer, bound to the top level.
// Depends on aes_cmac_signer ports only.
module acmac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] mac_high,
    input logic [63:0] mac_low
);
    // Stalled tag holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mac_high) && $stable(mac_low))
        else $error("tag changed while stalled");

    // No new word while a tag waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while tag pending");

    // A taken word is followed by busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after accept");

    // Tag never appears right after accept
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("tag too early");

endmodule

bind aes_cmac_signer acmac_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .mac_high, .mac_low
);
